// File: hdl/tbam_pkg.sv
// tbam_pkg: shared types and constants for the tracking box accuracy metrics block
// controller state codes, datapath command and status structs, field widths
// no dependencies
package tbam_pkg;

  localparam int DIST_W = 18;
  localparam int OVL_W = 17;
  localparam int CNT_W = 16;
  localparam int ESUM_W = 34;
  localparam int OSUM_W = 33;
  localparam int FRAC_W = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;

  // configuration register indexes
  localparam logic [0:0] REG_DIST_THR = 1'b0;
  localparam logic [0:0] REG_OVL_THR = 1'b1;

  typedef enum logic [2:0] {
    MUL_INTER,
    MUL_GAREA,
    MUL_TAREA,
    MUL_DX,
    MUL_DY,
    MUL_THR
  } mul_sel_t;

  typedef enum logic [2:0] {
    DIV_OVL,
    DIV_PREC,
    DIV_SUCC,
    DIV_MERR,
    DIV_MOVL
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_INTER,
    ST_MUL_GAREA,
    ST_MUL_TAREA,
    ST_DIV_OVL,
    ST_MUL_DY,
    ST_SQRT,
    ST_WAIT,
    ST_ACCUM,
    ST_PREC_S,
    ST_PREC_W,
    ST_SUCC_S,
    ST_SUCC_W,
    ST_MERR_S,
    ST_MERR_W,
    ST_MOVL_S,
    ST_MOVL_W,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_we;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     div_cap;
    div_sel_t div_sel;
    logic     sqrt_start;
    logic     accum;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic last;
  } dp_stat_t;

endpackage

// File: hdl/tracking_box_accuracy_metrics.sv
// tracking_box_accuracy_metrics: per-frame centre error and IoU with running
// tracking statistics; uses tbam_pkg, tbam_ctrl, tbam_dp (tbam_sqrt, tbam_div)
//
// Usage:
//   Input channel (in_valid/in_ready) takes one predicted box and one
//   ground-truth box per transfer, plus final_frame marking the last frame.
//   Output channel (out_valid/out_ready) gives one result per input: centre
//   error, IoU, hit flags and running counts; on a final frame it also gives
//   precision, success rate, mean error and mean IoU, then the statistics clear.
//   Config channel (cfg_valid/cfg_ready, always ready) writes index 0, the
//   distance threshold, or index 1, the overlap threshold; write only while idle.
// Timing:
//   the time of an ordinary frame is set by the bit-serial IoU division, which
//   runs alongside the bit-serial square root; a final frame adds four serial
//   divisions. One item is in work at a time: the next transfer is taken the
//   cycle after the result loads.
// Reset: thresholds go to 320 and 32768, counts and sums clear, no result valid.
// Stall: the result sits in the output register; the next item may be taken
//   meanwhile, and its result waits in the datapath until the register frees.
module tracking_box_accuracy_metrics
  import tbam_pkg::*;
#(
  parameter int COORD_BITS = 13,
  parameter int MAX_FRAMES = 65535
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [DIST_W-1:0]            cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] guess_x,
  input  logic signed [COORD_BITS-1:0] guess_y,
  input  logic [COORD_BITS-2:0]        guess_w,
  input  logic [COORD_BITS-2:0]        guess_h,
  input  logic signed [COORD_BITS-1:0] truth_x,
  input  logic signed [COORD_BITS-1:0] truth_y,
  input  logic [COORD_BITS-2:0]        truth_w,
  input  logic [COORD_BITS-2:0]        truth_h,
  input  logic                         final_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DIST_W-1:0]            centre_error,
  output logic [OVL_W-1:0]             overlap,
  output logic                         near_hit,
  output logic                         overlap_hit,
  output logic [CNT_W-1:0]             frames_seen,
  output logic [CNT_W-1:0]             near_total,
  output logic [CNT_W-1:0]             overlap_total,
  output logic [OVL_W-1:0]             precision_ratio,
  output logic [OVL_W-1:0]             success_ratio,
  output logic [DIST_W-1:0]            mean_centre_error,
  output logic [OVL_W-1:0]             mean_overlap
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  tbam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbam_dp #(
    .COORD_BITS(COORD_BITS),
    .MAX_FRAMES(MAX_FRAMES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .guess_x          (guess_x),
    .guess_y          (guess_y),
    .guess_w          (guess_w),
    .guess_h          (guess_h),
    .truth_x          (truth_x),
    .truth_y          (truth_y),
    .truth_w          (truth_w),
    .truth_h          (truth_h),
    .final_frame      (final_frame),
    .cmd              (cmd),
    .stat             (stat),
    .centre_error     (centre_error),
    .overlap          (overlap),
    .near_hit         (near_hit),
    .overlap_hit      (overlap_hit),
    .frames_seen      (frames_seen),
    .near_total       (near_total),
    .overlap_total    (overlap_total),
    .precision_ratio  (precision_ratio),
    .success_ratio    (success_ratio),
    .mean_centre_error(mean_centre_error),
    .mean_overlap     (mean_overlap)
  );

endmodule

// File: hdl/tbam_sqrt.sv
// tbam_sqrt: bit-serial integer square root, one root bit per cycle
// result floor(sqrt(radicand)) once busy falls; no package dependency
module tbam_sqrt #(
  parameter int RADW = 38
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RADW-1:0]   radicand,
  output logic              busy,
  output logic [RADW/2-1:0] root
);

  localparam int RTW = RADW / 2;
  localparam int CNTW = $clog2(RTW + 1);

  logic [RADW-1:0] rad;
  logic [RTW+1:0]  rem;
  logic [CNTW-1:0] cnt;
  logic [RTW+2:0]  shifted;
  logic [RTW+2:0]  trial;
  logic            ge;

  // restoring step: bring down two bits, try root*4+1
  always_comb begin
    shifted = {rem[RTW:0], rad[RADW-1 -: 2]};
    trial = (RTW+3)'({root, 2'b01});
    ge = shifted >= trial;
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNTW'(1)) begin
      busy <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      root <= '0;
      cnt <= CNTW'(RTW);
    end else if (busy) begin
      rad <= rad << 2;
      rem <= ge ? (RTW+2)'(shifted - trial) : shifted[RTW+1:0];
      root <= {root[RTW-2:0], ge};
      cnt <= cnt - CNTW'(1);
    end
  end

endmodule

// File: hdl/tbam_div.sv
// tbam_div: restoring divider, one quotient bit per cycle
// numerator is left-aligned, iters sets the quotient length; no package dependency
module tbam_div #(
  parameter int NW = 40,
  parameter int DW = 25,
  parameter int QW = 18,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [CW-1:0] iters,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quot
);

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [DW:0]   shifted;
  logic          ge;

  // compare partial remainder against divisor
  always_comb begin
    shifted = {rem, num_r[NW-1]};
    ge = shifted >= {1'b0, den_r};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem <= '0;
      quot <= '0;
      cnt <= iters;
    end else if (busy) begin
      num_r <= num_r << 1;
      rem <= ge ? DW'(shifted - {1'b0, den_r}) : shifted[DW-1:0];
      quot <= {quot[QW-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

endmodule

// File: hdl/tbam_dp.sv
// tbam_dp: datapath with shared multiplier, square root and divider units,
// accumulators, threshold registers and the output register; uses tbam_pkg,
// tbam_sqrt and tbam_div
module tbam_dp
  import tbam_pkg::*;
#(
  parameter int COORD_BITS = 13,
  parameter int MAX_FRAMES = 65535
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [DIST_W-1:0]            cfg_data,
  input  logic signed [COORD_BITS-1:0] guess_x,
  input  logic signed [COORD_BITS-1:0] guess_y,
  input  logic [COORD_BITS-2:0]        guess_w,
  input  logic [COORD_BITS-2:0]        guess_h,
  input  logic signed [COORD_BITS-1:0] truth_x,
  input  logic signed [COORD_BITS-1:0] truth_y,
  input  logic [COORD_BITS-2:0]        truth_w,
  input  logic [COORD_BITS-2:0]        truth_h,
  input  logic                         final_frame,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  output logic [DIST_W-1:0]            centre_error,
  output logic [OVL_W-1:0]             overlap,
  output logic                         near_hit,
  output logic                         overlap_hit,
  output logic [CNT_W-1:0]             frames_seen,
  output logic [CNT_W-1:0]             near_total,
  output logic [CNT_W-1:0]             overlap_total,
  output logic [OVL_W-1:0]             precision_ratio,
  output logic [OVL_W-1:0]             success_ratio,
  output logic [DIST_W-1:0]            mean_centre_error,
  output logic [OVL_W-1:0]             mean_overlap
);

  localparam int C = COORD_BITS;
  localparam int SW = C - 1;
  localparam int DXW = C + 3;
  localparam int AW = C + 2;
  localparam int MW = (AW > DIST_W) ? AW : DIST_W;
  localparam int PW = 2 * MW;
  localparam int IW = 2 * SW;
  localparam int DSW = 2 * AW;
  localparam int SQE = 2 * C + 12;
  localparam int RTW = SQE / 2;
  localparam int UW = IW + 1;
  localparam int DVW = (UW > CNT_W) ? UW : CNT_W;
  localparam int NW = (IW + FRAC_W > ESUM_W) ? IW + FRAC_W : ESUM_W;
  localparam int CW = $clog2(NW + 1);
  localparam int CNT_MAX = (MAX_FRAMES < 65535) ? MAX_FRAMES : 65535;

  // thresholds
  logic [DIST_W-1:0] dist_thr;
  logic [OVL_W-1:0]  ovl_thr;

  // captured item
  logic [SW-1:0] gw, gh, tw, th, spx, spy;
  logic [AW-1:0] dxa, dya;
  logic          last;

  // products
  logic [IW-1:0]       inter, garea, tarea;
  logic [DSW-1:0]      sx, sy;
  logic [2*DIST_W-1:0] thr2;

  // per-frame results
  logic [OVL_W-1:0]  ovl_r;
  logic [DIST_W-1:0] dist_r;
  logic              near_r, ohit_r;
  logic [OVL_W-1:0]  prec_r, succ_r, movl_r;
  logic [DIST_W-1:0] merr_r;

  // accumulators
  logic [CNT_W-1:0]  frame_count, near_count, overlap_count;
  logic [ESUM_W-1:0] error_sum;
  logic [OSUM_W-1:0] overlap_sum;

  logic signed [DXW-1:0] gcx, tcx, gcy, tcy, dx_c, dy_c;
  logic [MW-1:0]         mul_a, mul_b;
  logic [PW-1:0]         prod;
  logic [UW-1:0]         uni;
  logic [SQE-1:0]        sq;
  logic [RTW-1:0]        root;
  logic                  sqrt_busy, div_busy;
  logic [NW-1:0]         div_num;
  logic [CW-1:0]         div_iters;
  logic [DVW-1:0]        div_den;
  logic [DIST_W-1:0]     div_quot;
  logic [DIST_W-1:0]     dist_c;
  logic                  near_c, ohit_c;
  logic [ESUM_W:0]       esum_add;
  logic [OSUM_W:0]       osum_add;

  // overlap of two half-open intervals
  function automatic logic [SW-1:0] span_f(input logic signed [C-1:0] a,
                                           input logic [SW-1:0] aw,
                                           input logic signed [C-1:0] b,
                                           input logic [SW-1:0] bw);
    logic signed [C:0]   a_lo, a_hi, b_lo, b_hi, lo, hi;
    logic signed [C+1:0] d;
    a_lo = (C+1)'(a);
    b_lo = (C+1)'(b);
    a_hi = a_lo + signed'((C+1)'(aw));
    b_hi = b_lo + signed'((C+1)'(bw));
    lo = (a_lo > b_lo) ? a_lo : b_lo;
    hi = (a_hi < b_hi) ? a_hi : b_hi;
    d = (C+2)'(hi) - (C+2)'(lo);
    return (hi > lo) ? SW'(d) : '0;
  endfunction

  // doubled centre differences
  always_comb begin
    gcx = (DXW'(guess_x) <<< 1) + signed'(DXW'(guess_w));
    tcx = (DXW'(truth_x) <<< 1) + signed'(DXW'(truth_w));
    gcy = (DXW'(guess_y) <<< 1) + signed'(DXW'(guess_h));
    tcy = (DXW'(truth_y) <<< 1) + signed'(DXW'(truth_h));
    dx_c = gcx - tcx;
    dy_c = gcy - tcy;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      gw <= guess_w;
      gh <= guess_h;
      tw <= truth_w;
      th <= truth_h;
      spx <= span_f(guess_x, guess_w, truth_x, truth_w);
      spy <= span_f(guess_y, guess_h, truth_y, truth_h);
      dxa <= dx_c[DXW-1] ? AW'(-dx_c) : AW'(dx_c);
      dya <= dy_c[DXW-1] ? AW'(-dy_c) : AW'(dy_c);
      last <= final_frame;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_INTER: begin mul_a = MW'(spx); mul_b = MW'(spy); end
      MUL_GAREA: begin mul_a = MW'(gw); mul_b = MW'(gh); end
      MUL_TAREA: begin mul_a = MW'(tw); mul_b = MW'(th); end
      MUL_DX:    begin mul_a = MW'(dxa); mul_b = MW'(dxa); end
      MUL_DY:    begin mul_a = MW'(dya); mul_b = MW'(dya); end
      MUL_THR:   begin mul_a = MW'(dist_thr); mul_b = MW'(dist_thr); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  // product registers
  always_ff @(posedge clk) begin
    if (cmd.mul_we) begin
      case (cmd.mul_sel)
        MUL_INTER: inter <= prod[IW-1:0];
        MUL_GAREA: garea <= prod[IW-1:0];
        MUL_TAREA: tarea <= prod[IW-1:0];
        MUL_DX:    sx <= prod[DSW-1:0];
        MUL_DY:    sy <= prod[DSW-1:0];
        MUL_THR:   thr2 <= prod[2*DIST_W-1:0];
        default:   ;
      endcase
    end
  end

  // union area and squared scaled distance
  always_comb begin
    uni = UW'(garea) + UW'(tarea) - UW'(inter);
    sq = (SQE'(sx) + SQE'(sy)) << 6;
  end

  tbam_sqrt #(
    .RADW(SQE)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.sqrt_start),
    .radicand(sq),
    .busy    (sqrt_busy),
    .root    (root)
  );

  // divider operand select, numerators left-aligned
  always_comb begin
    case (cmd.div_sel)
      DIV_OVL: begin
        div_num = NW'({inter, 16'h0}) << (NW - IW - FRAC_W);
        div_iters = CW'(IW + FRAC_W);
        div_den = DVW'(uni);
      end
      DIV_PREC: begin
        div_num = NW'({near_count, 16'h0}) << (NW - CNT_W - FRAC_W);
        div_iters = CW'(CNT_W + FRAC_W);
        div_den = DVW'(frame_count);
      end
      DIV_SUCC: begin
        div_num = NW'({overlap_count, 16'h0}) << (NW - CNT_W - FRAC_W);
        div_iters = CW'(CNT_W + FRAC_W);
        div_den = DVW'(frame_count);
      end
      DIV_MERR: begin
        div_num = NW'(error_sum) << (NW - ESUM_W);
        div_iters = CW'(ESUM_W);
        div_den = DVW'(frame_count);
      end
      DIV_MOVL: begin
        div_num = NW'(overlap_sum) << (NW - OSUM_W);
        div_iters = CW'(OSUM_W);
        div_den = DVW'(frame_count);
      end
      default: begin
        div_num = '0;
        div_iters = '0;
        div_den = '0;
      end
    endcase
  end

  tbam_div #(
    .NW(NW),
    .DW(DVW),
    .QW(DIST_W),
    .CW(CW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .iters(div_iters),
    .den  (div_den),
    .busy (div_busy),
    .quot (div_quot)
  );

  // quotient capture
  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.div_sel)
        DIV_OVL:  ovl_r <= (uni == '0) ? '0 : div_quot[OVL_W-1:0];
        DIV_PREC: prec_r <= div_quot[OVL_W-1:0];
        DIV_SUCC: succ_r <= div_quot[OVL_W-1:0];
        DIV_MERR: merr_r <= div_quot;
        DIV_MOVL: movl_r <= div_quot[OVL_W-1:0];
        default:  ;
      endcase
    end
  end

  // per-frame decisions and saturating sums
  always_comb begin
    dist_c = (32'(root) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(root);
    near_c = 64'(sq) <= 64'(thr2);
    ohit_c = ovl_r >= ovl_thr;
    esum_add = (ESUM_W+1)'(error_sum) + (ESUM_W+1)'(dist_c);
    osum_add = (OSUM_W+1)'(overlap_sum) + (OSUM_W+1)'(ovl_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      dist_r <= dist_c;
      near_r <= near_c;
      ohit_r <= ohit_c;
    end
  end

  // thresholds and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr <= DIST_W'(320);
      ovl_thr <= OVL_W'(32768);
      frame_count <= '0;
      near_count <= '0;
      overlap_count <= '0;
      error_sum <= '0;
      overlap_sum <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIST_THR: dist_thr <= cfg_data;
          REG_OVL_THR:  ovl_thr <= cfg_data[OVL_W-1:0];
          default:      ;
        endcase
      end
      if (cmd.accum && frame_count < CNT_W'(CNT_MAX)) begin
        frame_count <= frame_count + CNT_W'(1);
        if (near_c) near_count <= near_count + CNT_W'(1);
        if (ohit_c) overlap_count <= overlap_count + CNT_W'(1);
        error_sum <= esum_add[ESUM_W] ? '1 : esum_add[ESUM_W-1:0];
        overlap_sum <= osum_add[OSUM_W] ? '1 : osum_add[OSUM_W-1:0];
      end
      if (cmd.emit && last) begin
        frame_count <= '0;
        near_count <= '0;
        overlap_count <= '0;
        error_sum <= '0;
        overlap_sum <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      centre_error <= dist_r;
      overlap <= ovl_r;
      near_hit <= near_r;
      overlap_hit <= ohit_r;
      frames_seen <= frame_count;
      near_total <= near_count;
      overlap_total <= overlap_count;
      precision_ratio <= last ? prec_r : '0;
      success_ratio <= last ? succ_r : '0;
      mean_centre_error <= last ? merr_r : '0;
      mean_overlap <= last ? movl_r : '0;
    end
  end

  assign stat.sqrt_busy = sqrt_busy;
  assign stat.div_busy = div_busy;
  assign stat.last = last;

endmodule

// File: hdl/tbam_ctrl.sv
// tbam_ctrl: sequencing state machine, input/output handshakes
// drives dp_cmd_t into the datapath; uses tbam_pkg
module tbam_ctrl
  import tbam_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  // state register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL_INTER;
      ST_MUL_INTER: state_next = ST_MUL_GAREA;
      ST_MUL_GAREA: state_next = ST_MUL_TAREA;
      ST_MUL_TAREA: state_next = ST_DIV_OVL;
      ST_DIV_OVL:   state_next = ST_MUL_DY;
      ST_MUL_DY:    state_next = ST_SQRT;
      ST_SQRT:      state_next = ST_WAIT;
      ST_WAIT:      if (!stat.sqrt_busy && !stat.div_busy) state_next = ST_ACCUM;
      ST_ACCUM:     state_next = stat.last ? ST_PREC_S : ST_EMIT;
      ST_PREC_S:    state_next = ST_PREC_W;
      ST_PREC_W:    if (!stat.div_busy) state_next = ST_SUCC_S;
      ST_SUCC_S:    state_next = ST_SUCC_W;
      ST_SUCC_W:    if (!stat.div_busy) state_next = ST_MERR_S;
      ST_MERR_S:    state_next = ST_MERR_W;
      ST_MERR_W:    if (!stat.div_busy) state_next = ST_MOVL_S;
      ST_MOVL_S:    state_next = ST_MOVL_W;
      ST_MOVL_W:    if (!stat.div_busy) state_next = ST_EMIT;
      ST_EMIT:      if (slot_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_MUL_INTER: begin
        cmd.mul_we = 1'b1;
        cmd.mul_sel = MUL_INTER;
      end
      ST_MUL_GAREA: begin
        cmd.mul_we = 1'b1;
        cmd.mul_sel = MUL_GAREA;
      end
      ST_MUL_TAREA: begin
        cmd.mul_we = 1'b1;
        cmd.mul_sel = MUL_TAREA;
      end
      ST_DIV_OVL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_OVL;
        cmd.mul_we = 1'b1;
        cmd.mul_sel = MUL_DX;
      end
      ST_MUL_DY: begin
        cmd.mul_we = 1'b1;
        cmd.mul_sel = MUL_DY;
      end
      ST_SQRT: begin
        cmd.sqrt_start = 1'b1;
        cmd.mul_we = 1'b1;
        cmd.mul_sel = MUL_THR;
      end
      ST_WAIT: begin
        cmd.div_sel = DIV_OVL;
        cmd.div_cap = !stat.sqrt_busy && !stat.div_busy;
      end
      ST_ACCUM: cmd.accum = 1'b1;
      ST_PREC_S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_PREC;
      end
      ST_PREC_W: begin
        cmd.div_sel = DIV_PREC;
        cmd.div_cap = !stat.div_busy;
      end
      ST_SUCC_S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_SUCC;
      end
      ST_SUCC_W: begin
        cmd.div_sel = DIV_SUCC;
        cmd.div_cap = !stat.div_busy;
      end
      ST_MERR_S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_MERR;
      end
      ST_MERR_W: begin
        cmd.div_sel = DIV_MERR;
        cmd.div_cap = !stat.div_busy;
      end
      ST_MOVL_S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_MOVL;
      end
      ST_MOVL_W: begin
        cmd.div_sel = DIV_MOVL;
        cmd.div_cap = !stat.div_busy;
      end
      ST_EMIT: cmd.emit = slot_free;
      default: ;
    endcase
  end

endmodule
